@@ src/arw_pkg.sv @@
package arw_pkg;

	localparam int WORD_BITS        = 32;
	localparam int WORD_SHIFT       = 5;
	localparam int WINDOW_WORDS_DEF = 8;
	localparam int SEQ_W            = 64;
	localparam int WSIZE_W          = 9;
	localparam logic [WSIZE_W-1:0] WSIZE_RST = 9'd256;

	localparam int APB_DATA_W = 32;
	localparam int PADDR_W    = 3;

	// register index, taken from paddr above the byte offset
	localparam logic [PADDR_W-3:0] REG_WINDOW_SIZE = '0;

	localparam logic OP_CHECK  = 1'b0;
	localparam logic OP_UPDATE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DECIDE,
		ST_CLEAR,
		ST_READ,
		ST_TEST,
		ST_DONE
	} state_t;

endpackage

@@ src/anti_replay_window.sv @@
// anti-replay check over a word-organized bitmap held in a synchronous memory
// steps: eval, decide, a clear sweep of up to the effective word count of words (updates above
//   the highest only), read, test; disabled, zero, too-old items and checks above the highest end at decide
// a new item is taken only in idle, once the last result has moved to the output register;
//   a result may wait in the output register
// reset: highest seen 0, bitmap reads zero through per-word valid bits, window_size 256
module anti_replay_window
	import arw_pkg::*;
#(
	parameter int WINDOW_WORDS = WINDOW_WORDS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  operation,
	input  logic [SEQ_W-1:0]      sequence_req,

	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  accept,

	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int IDX_W  = (WINDOW_WORDS > 1) ? $clog2(WINDOW_WORDS) : 1;
	localparam int WCNT_W = $clog2(WINDOW_WORDS + 1);
	localparam int CW     = (WCNT_W > 4) ? WCNT_W : 4;
	localparam int HW     = SEQ_W - WORD_SHIFT;

	state_t state_q, state_d;

	logic [WSIZE_W-1:0]   window_size_q;
	logic                 op_q;
	logic [SEQ_W-1:0]     seq_q;
	logic [SEQ_W-1:0]     highest_q;
	logic [SEQ_W-1:0]     lim_q;
	logic                 dis_q, zero_q, gt_q, hsbig_q;
	logic [WCNT_W-1:0]    cnt_q;
	logic [IDX_W-1:0]     caddr_q;
	logic                 res_q;
	logic                 out_valid_q;
	logic                 out_accept_q;

	logic [WORD_BITS-1:0] mem [WINDOW_WORDS];
	logic [WINDOW_WORDS-1:0] vld_q;
	logic [WORD_BITS-1:0] rd_q;
	logic                 rvld_q;

	// apb
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & (paddr[PADDR_W-1:2] == REG_WINDOW_SIZE);
	assign prdata = (paddr[PADDR_W-1:2] == REG_WINDOW_SIZE) ?
		APB_DATA_W'(window_size_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= WSIZE_RST;
		end else if (cfg_wr) begin
			window_size_q <= pwdata[WSIZE_W-1:0];
		end
	end

	// effective word count: clamp to 1..WINDOW_WORDS, round down to a power of two
	logic [CW-1:0]     wreq, wclamp, wpow;
	logic [WCNT_W-1:0] words;
	logic [IDX_W-1:0]  mask;
	logic [SEQ_W-1:0]  span;

	always_comb begin
		wreq = CW'(window_size_q[WSIZE_W-1:WORD_SHIFT]);
		if (wreq == '0)
			wclamp = CW'(1);
		else if (wreq > CW'(WINDOW_WORDS))
			wclamp = CW'(WINDOW_WORDS);
		else
			wclamp = wreq;
		wpow = '0;
		for (int i = 0; i < CW; i++) begin
			if (wclamp[i])
				wpow = CW'(1) << i;
		end
		words = WCNT_W'(wpow);
		mask  = IDX_W'(words - WCNT_W'(1));
		span  = SEQ_W'(words) << WORD_SHIFT;
	end

	// datapath terms
	logic [SEQ_W:0]   hdiff;
	logic             old;
	logic [HW-1:0]    wdist;
	logic [WCNT_W-1:0] sat;
	logic [IDX_W-1:0] tidx;
	logic [WORD_BITS-1:0] tword, tbit;
	logic             hit;

	assign hdiff = {1'b0, highest_q} - {1'b0, span};
	assign old   = hsbig_q && (seq_q < lim_q);
	assign wdist = seq_q[SEQ_W-1:WORD_SHIFT] - highest_q[SEQ_W-1:WORD_SHIFT];
	assign sat   = (wdist > HW'(words)) ? words : WCNT_W'(wdist);
	assign tidx  = seq_q[WORD_SHIFT +: IDX_W] & mask;
	assign tword = rvld_q ? rd_q : '0;
	assign tbit  = WORD_BITS'(1) << seq_q[WORD_SHIFT-1:0];
	assign hit   = (tword & tbit) != '0;

	// fsm
	logic             in_fire, out_free;
	logic             we;
	logic [IDX_W-1:0] waddr;
	logic [WORD_BITS-1:0] wdata;
	logic             ld_in, ld_eval, set_res, res_val, ld_clear, raise_hs, step_clr, do_rd;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid & in_ready;
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		ld_in    = 1'b0;
		ld_eval  = 1'b0;
		set_res  = 1'b0;
		res_val  = 1'b0;
		ld_clear = 1'b0;
		raise_hs = 1'b0;
		step_clr = 1'b0;
		do_rd    = 1'b0;
		we       = 1'b0;
		waddr    = caddr_q;
		wdata    = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					ld_in   = 1'b1;
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				ld_eval = 1'b1;
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (dis_q) begin
					set_res = 1'b1;
					res_val = 1'b1;
					state_d = ST_DONE;
				end else if (zero_q) begin
					set_res = 1'b1;
					state_d = ST_DONE;
				end else if (op_q == OP_CHECK) begin
					if (gt_q) begin
						set_res = 1'b1;
						res_val = 1'b1;
						state_d = ST_DONE;
					end else if (old) begin
						set_res = 1'b1;
						state_d = ST_DONE;
					end else begin
						state_d = ST_READ;
					end
				end else begin
					if (old) begin
						set_res = 1'b1;
						state_d = ST_DONE;
					end else if (gt_q) begin
						raise_hs = 1'b1;
						ld_clear = 1'b1;
						state_d  = (sat != '0) ? ST_CLEAR : ST_READ;
					end else begin
						state_d = ST_READ;
					end
				end
			end
			ST_CLEAR: begin
				we       = 1'b1;
				step_clr = 1'b1;
				if (cnt_q == WCNT_W'(1))
					state_d = ST_READ;
			end
			ST_READ: begin
				do_rd   = 1'b1;
				state_d = ST_TEST;
			end
			ST_TEST: begin
				set_res = 1'b1;
				res_val = !hit;
				if (op_q == OP_UPDATE && !hit) begin
					we    = 1'b1;
					waddr = tidx;
					wdata = tword | tbit;
				end
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// item registers
	always_ff @(posedge clk) begin
		if (ld_in) begin
			op_q  <= operation;
			seq_q <= sequence_req;
		end
		if (ld_eval) begin
			dis_q   <= (window_size_q == '0);
			zero_q  <= (seq_q == '0);
			gt_q    <= (seq_q > highest_q);
			hsbig_q <= !hdiff[SEQ_W] && (hdiff[SEQ_W-1:0] != '0);
			lim_q   <= hdiff[SEQ_W-1:0];
		end
		if (set_res)
			res_q <= res_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			highest_q <= '0;
			cnt_q     <= '0;
			caddr_q   <= '0;
		end else begin
			if (raise_hs)
				highest_q <= seq_q;
			if (ld_clear) begin
				cnt_q   <= sat;
				caddr_q <= (highest_q[WORD_SHIFT +: IDX_W] + IDX_W'(1)) & mask;
			end else if (step_clr) begin
				cnt_q   <= cnt_q - WCNT_W'(1);
				caddr_q <= (caddr_q + IDX_W'(1)) & mask;
			end
		end
	end

	// bitmap memory; clears finish before the read and the write-back lands before
	// the next item can read, so no two accesses to one word overlap
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (do_rd)
			rd_q <= mem[tidx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (we)
				vld_q[waddr] <= 1'b1;
			if (do_rd)
				rvld_q <= vld_q[tidx];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			out_accept_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q  <= 1'b1;
			out_accept_q <= res_q;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign accept    = out_accept_q;

`ifndef ASSERT_OFF
	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == ST_CLEAR || state_q == ST_TEST))
		else $error("bitmap write outside clear or test");

	a_clear_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> (cnt_q != '0 && cnt_q <= words))
		else $error("clear count out of range");

	a_highest_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (highest_q >= $past(highest_q)))
		else $error("highest seen decreased");

	a_disabled_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECIDE && dis_q) |=> (res_q && state_q == ST_DONE))
		else $error("disabled window did not accept");

	a_no_mark_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TEST) |-> (seq_q != '0 && !dis_q))
		else $error("bitmap test for zero sequence or disabled window");
`endif

endmodule

@@ sim/tb.sv @@
module tb
	import arw_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic             accept;
		logic             op;
		logic [SEQ_W-1:0] seq;
	} verdict_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic                  operation;
	logic [SEQ_W-1:0]      sequence_req;
	logic                  out_valid;
	logic                  out_ready;
	logic                  accept;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [PADDR_W-1:0]    paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	// shadow of the window state
	logic [SEQ_W-1:0]     top_seen;
	logic [WORD_BITS-1:0] seen_words [WINDOW_WORDS_DEF];
	logic [WSIZE_W-1:0]   window_reg;

	verdict_t       pending [$];
	logic [SEQ_W-1:0] recent [16];
	int             recent_wr;
	int             fail_count;
	int             quiet;
	logic           steady_send;
	logic           eager_recv;
	logic           long_hold;

	anti_replay_window dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.sequence_req(sequence_req),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.accept(accept),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int live_words(logic [WSIZE_W-1:0] ws);
		int w;
		int p;
		w = int'(ws >> WORD_SHIFT);
		p = 1;
		if (w < 1) w = 1;
		if (w > WINDOW_WORDS_DEF) w = WINDOW_WORDS_DEF;
		while (p * 2 <= w) p = p * 2;
		return p;
	endfunction

	// expected verdict for one transaction; updates advance the shadow state
	function automatic logic window_verdict(logic op, logic [SEQ_W-1:0] seq);
		logic [SEQ_W-1:0]     words;
		logic [SEQ_W-1:0]     mask;
		logic [SEQ_W-1:0]     span;
		logic [SEQ_W-1:0]     cur;
		logic [SEQ_W-1:0]     jump;
		logic [SEQ_W-1:0]     idx;
		logic [WORD_BITS-1:0] lane;
		logic                 stale;
		if (window_reg == '0) return 1'b1;
		if (seq == '0) return 1'b0;
		words = SEQ_W'(live_words(window_reg));
		mask = words - 1;
		span = words * WORD_BITS;
		stale = (top_seen > span) && (seq < top_seen - span);
		idx = (seq >> WORD_SHIFT) & mask;
		lane = 32'd1 << seq[WORD_SHIFT-1:0];
		if (op == OP_CHECK) begin
			if (seq > top_seen) return 1'b1;
			if (stale) return 1'b0;
			return (seen_words[idx[2:0]] & lane) == '0;
		end
		if (stale) return 1'b0;
		if (seq > top_seen) begin
			cur = top_seen >> WORD_SHIFT;
			jump = (seq >> WORD_SHIFT) - cur;
			if (jump > words) jump = words;
			for (int i = 0; i < int'(jump); i++)
				seen_words[3'((cur + 1 + SEQ_W'(i)) & mask)] = '0;
			top_seen = seq;
		end
		if ((seen_words[idx[2:0]] & lane) != '0) return 1'b0;
		seen_words[idx[2:0]] = seen_words[idx[2:0]] | lane;
		return 1'b1;
	endfunction

	function automatic int pace_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	// mostly numbers around the highest seen, some replays, zeros and noise
	function automatic logic [SEQ_W-1:0] pick_sequence();
		logic [SEQ_W-1:0] span;
		logic [SEQ_W-1:0] d;
		logic [SEQ_W-1:0] sum;
		int               r;
		span = SEQ_W'(live_words(window_reg) * WORD_BITS);
		r = $urandom_range(0, 99);
		if (r < 45) begin
			d = SEQ_W'($urandom_range(1, 40));
		end else if (r < 75) begin
			d = SEQ_W'($urandom_range(0, 64)) + span;
			d = SEQ_W'($urandom_range(0, int'(d)));
			return (d <= top_seen) ? top_seen - d : d;
		end else if (r < 85) begin
			d = SEQ_W'($urandom_range(1, 12) * WORD_BITS + $urandom_range(0, 31));
		end else if (r < 92) begin
			return recent[$urandom_range(0, 15)];
		end else if (r < 96) begin
			return '0;
		end else begin
			return {$urandom, $urandom};
		end
		sum = top_seen + d;
		return (sum < top_seen) ? '1 : sum;
	endfunction

	task automatic flag_error(string what);
		fail_count++;
		if (fail_count <= 10) $display("%s", what);
	endtask

	task automatic send_item(logic op, logic [SEQ_W-1:0] seq);
		int       gap;
		verdict_t v;
		gap = steady_send ? 0 : pace_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		operation <= op;
		sequence_req <= seq;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		v.accept = window_verdict(op, seq);
		v.op = op;
		v.seq = seq;
		pending.push_back(v);
		recent[recent_wr] = seq;
		recent_wr = (recent_wr + 1) % 16;
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// write the window size, then read it back
	task automatic set_window(logic [WSIZE_W-1:0] ws);
		drain();
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_WINDOW_SIZE, 2'b00};
		pwdata <= APB_DATA_W'(ws);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		window_reg = ws;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata[WSIZE_W-1:0] !== window_reg)
			flag_error($sformatf("window_size read: expected %0d got %0d",
				window_reg, prdata[WSIZE_W-1:0]));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic run_stream(int n, logic vary_pace);
		logic op;
		for (int i = 0; i < n; i++) begin
			if (vary_pace && i % 50 == 0) begin
				steady_send = ($urandom_range(0, 3) == 0);
				eager_recv = ($urandom_range(0, 3) == 0);
			end
			op = ($urandom_range(0, 99) < 70) ? OP_UPDATE : OP_CHECK;
			send_item(op, pick_sequence());
		end
	endtask

	task automatic test_directed();
		send_item(OP_CHECK, 64'd0);
		send_item(OP_UPDATE, 64'd0);
		send_item(OP_CHECK, 64'd1);
		send_item(OP_UPDATE, 64'd1);
		send_item(OP_UPDATE, 64'd1);
		send_item(OP_CHECK, 64'd1);
		send_item(OP_UPDATE, 64'd5);
		send_item(OP_UPDATE, 64'd3);
		send_item(OP_CHECK, 64'd3);
		send_item(OP_CHECK, 64'd4);
		// jump of more than the whole window
		send_item(OP_UPDATE, 64'd1000);
		send_item(OP_CHECK, 64'd3);
		// right at the old edge, then one past it
		send_item(OP_UPDATE, 64'd744);
		send_item(OP_UPDATE, 64'd743);
		send_item(OP_CHECK, 64'd744);
		send_item(OP_UPDATE, 64'd1032);
		send_item(OP_UPDATE, 64'd1100);
		send_item(OP_CHECK, '1);
		send_item(OP_UPDATE, 64'd999);
	endtask

	task automatic test_window_off();
		set_window('0);
		send_item(OP_UPDATE, 64'd0);
		send_item(OP_CHECK, 64'd0);
		send_item(OP_UPDATE, 64'd1);
		send_item(OP_CHECK, 64'd1);
		run_stream(60, 1'b1);
	endtask

	task automatic test_power_sizes();
		set_window(9'd32);
		run_stream(150, 1'b1);
		set_window(9'd64);
		run_stream(150, 1'b1);
		set_window(9'd128);
		run_stream(150, 1'b1);
		set_window(9'd256);
		run_stream(250, 1'b1);
	endtask

	// sizes that are not a power-of-two word count get rounded down, and below one word clamped to one
	task automatic test_odd_sizes();
		set_window(9'd1);
		run_stream(80, 1'b1);
		set_window(9'd100);
		run_stream(80, 1'b1);
		set_window(9'd200);
		run_stream(80, 1'b1);
		set_window(9'd255);
		run_stream(80, 1'b1);
	endtask

	// receiver stops for a long while so the block fills and stalls its input
	task automatic test_backpressure();
		set_window(9'd256);
		steady_send = 1'b1;
		long_hold = 1'b1;
		run_stream(60, 1'b0);
		steady_send = 1'b0;
	endtask

	task automatic test_top_of_range();
		set_window(9'd256);
		send_item(OP_UPDATE, 64'hFFFF_FFFF_FFFF_FF00);
		send_item(OP_UPDATE, '1);
		send_item(OP_UPDATE, '1);
		send_item(OP_CHECK, '1);
		send_item(OP_UPDATE, 64'hFFFF_FFFF_FFFF_FFFE);
		send_item(OP_UPDATE, 64'hFFFF_FFFF_FFFF_FED3);
		send_item(OP_CHECK, 64'd1);
		send_item(OP_CHECK, 64'h8000_0000_0000_0000);
		run_stream(60, 1'b1);
	endtask

	// receiver side: random stalls, eager stretches and one long hold
	initial begin : receiver
		int stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				long_hold = 1'b0;
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				if (!eager_recv) stall_left = pace_gap();
			end
		end
	end

	always @(posedge clk) begin : check_result
		verdict_t v;
		if (arst_n && out_valid && out_ready) begin
			if (pending.size() == 0) begin
				flag_error($sformatf("unexpected transaction: accept %0b", accept));
			end else begin
				v = pending.pop_front();
				if (accept !== v.accept)
					flag_error($sformatf("op %0d seq %0h: accept expected %0b got %0b",
						v.op, v.seq, v.accept, accept));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_CHECK;
		sequence_req = '0;
		out_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		quiet = 0;
		fail_count = 0;
		recent_wr = 0;
		steady_send = 1'b0;
		eager_recv = 1'b0;
		long_hold = 1'b0;
		top_seen = '0;
		window_reg = WSIZE_RST;
		for (int i = 0; i < WINDOW_WORDS_DEF; i++) seen_words[i] = '0;
		for (int i = 0; i < 16; i++) recent[i] = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_window_off();
		test_power_sizes();
		test_odd_sizes();
		test_backpressure();
		test_top_of_range();
		drain();

		if (fail_count == 0 && pending.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
